// ===== sv/odt_pkg.sv =====
// Shared types and codes for the ordered task dispatch table.
// Used by odt_table, odt_match and ordered_task_dispatch_table_top; depends on nothing.
package odt_pkg;

  // Field widths that do not vary with the module parameters.
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 4;

  // Request codes carried in the input word.
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD       = 3'd0,
    REQ_ABORT     = 3'd1,
    REQ_ABORT_ALL = 3'd2,
    REQ_FETCH     = 3'd3,
    REQ_RETURN    = 3'd4
  } req_code_e;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED     = 4'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_FETCHED   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_NONE      = 4'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_PENDING   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_UNBLOCKED = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_DOUBLE    = 4'd8;

  // Operations the sequencer issues to the table.
  typedef enum logic [2:0] {
    TBL_NOP,
    TBL_APPEND,
    TBL_SET_BUSY,
    TBL_CLR_BUSY,
    TBL_SET_PEND,
    TBL_REMOVE,
    TBL_SNAP
  } tbl_op_e;

  // Status marks of the entry under the scan pointer.
  typedef struct packed {
    logic valid;
    logic busy;
    logic pend;
  } slot_flags_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } seq_state_e;

endpackage

// ===== sv/odt_table.sv =====
// Task table: entries packed in arrival order, with append, mark and remove-with-shift.
// Also holds the id snapshot used by abort-all. Depends on odt_pkg.
module odt_table #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned ID_WIDTH     = 16,
  parameter int unsigned HANDLE_WIDTH = 32,
  localparam int unsigned IW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  odt_pkg::tbl_op_e        op,
  input  logic [IW-1:0]           pos,
  input  logic [ID_WIDTH-1:0]     wr_id,
  input  logic [HANDLE_WIDTH-1:0] wr_handle,
  input  logic [IW-1:0]           rd_idx,
  input  logic [IW-1:0]           snap_idx,
  output odt_pkg::slot_flags_t    rd_flags,
  output logic [ID_WIDTH-1:0]     rd_id,
  output logic [HANDLE_WIDTH-1:0] rd_handle,
  output logic [ID_WIDTH-1:0]     snap_id,
  output logic [CW-1:0]           count
);

  logic [DEPTH-1:0]        valid_r;
  logic [DEPTH-1:0]        busy_r;
  logic [DEPTH-1:0]        pend_r;
  logic [ID_WIDTH-1:0]     id_r     [DEPTH];
  logic [HANDLE_WIDTH-1:0] handle_r [DEPTH];
  logic [ID_WIDTH-1:0]     snap_r   [DEPTH];
  logic [CW-1:0]           count_r;

  // Status marks and fill count; a removal shifts younger entries down by one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r  <= '0;
      pend_r  <= '0;
      count_r <= '0;
    end else begin
      case (op)
        odt_pkg::TBL_APPEND: begin
          valid_r[count_r[IW-1:0]] <= 1'b1;
          busy_r[count_r[IW-1:0]]  <= 1'b0;
          pend_r[count_r[IW-1:0]]  <= 1'b0;
          count_r                  <= count_r + CW'(1);
        end
        odt_pkg::TBL_SET_BUSY: busy_r[pos] <= 1'b1;
        odt_pkg::TBL_CLR_BUSY: busy_r[pos] <= 1'b0;
        odt_pkg::TBL_SET_PEND: pend_r[pos] <= 1'b1;
        odt_pkg::TBL_REMOVE: begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (IW'(i) >= pos) begin
              valid_r[i] <= valid_r[i+1];
              busy_r[i]  <= busy_r[i+1];
              pend_r[i]  <= pend_r[i+1];
            end
          end
          valid_r[DEPTH-1] <= 1'b0;
          busy_r[DEPTH-1]  <= 1'b0;
          pend_r[DEPTH-1]  <= 1'b0;
          count_r          <= count_r - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Ids and handles carry no reset; entries are only read while valid.
  always_ff @(posedge clk) begin
    case (op)
      odt_pkg::TBL_APPEND: begin
        id_r[count_r[IW-1:0]]     <= wr_id;
        handle_r[count_r[IW-1:0]] <= wr_handle;
      end
      odt_pkg::TBL_REMOVE: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (IW'(i) >= pos) begin
            id_r[i]     <= id_r[i+1];
            handle_r[i] <= handle_r[i+1];
          end
        end
      end
      odt_pkg::TBL_SNAP: begin
        for (int i = 0; i < DEPTH; i++) begin
          snap_r[i] <= id_r[i];
        end
      end
      default: ;
    endcase
  end

  // Single read port at the scan pointer, and one into the snapshot.
  assign rd_flags.valid = valid_r[rd_idx];
  assign rd_flags.busy  = busy_r[rd_idx];
  assign rd_flags.pend  = pend_r[rd_idx];
  assign rd_id          = id_r[rd_idx];
  assign rd_handle      = handle_r[rd_idx];
  assign snap_id        = snap_r[snap_idx];
  assign count          = count_r;

endmodule

// ===== sv/odt_match.sv =====
// Shared compare unit: decides whether the entry under the scan pointer answers the request.
// Depends on odt_pkg.
module odt_match #(
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic                 fetch_mode,
  input  logic [ID_WIDTH-1:0]  key,
  input  odt_pkg::slot_flags_t flags,
  input  logic [ID_WIDTH-1:0]  entry_id,
  output logic                 hit
);

  // A fetch wants an idle entry; the other lookups want the id, and id zero never matches.
  always_comb begin
    if (fetch_mode) begin
      hit = flags.valid && !flags.busy && !flags.pend;
    end else begin
      hit = flags.valid && (key != '0) && (entry_id == key);
    end
  end

endmodule

// ===== sv/ordered_task_dispatch_table_top.sv =====
// Ordered task dispatch table: top level with the scan sequencer and the result register.
// Depends on odt_pkg, odt_table and odt_match.
//
// Requests enter as one word each and the block takes no new word until the current
// request has loaded its last result word. An add, or an unused request code, resolves
// without a walk. Abort, fetch and return walk the table from the oldest entry through
// one shared compare unit, one entry per cycle, and stop at the first matching entry or,
// when nothing matches, at the last entry. Abort-all repeats that walk once for each
// entry present on arrival, or once when the table is empty, and gives one result word
// per walk. A result that cannot be handed on holds the sequencer until the output
// register frees; the next request can be taken while the last result still waits.
module ordered_task_dispatch_table_top #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned ID_WIDTH     = 16,
  parameter int unsigned HANDLE_WIDTH = 32,
  localparam int unsigned IN_BITS  = odt_pkg::REQ_W + ID_WIDTH + HANDLE_WIDTH,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = odt_pkg::STATUS_W + ID_WIDTH + HANDLE_WIDTH + 1,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // From bit 0: req_type, task_id, task_handle, zero fill.
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // From bit 0: status, out_id, out_handle, newly_available, zero fill.
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int unsigned IW        = $clog2(DEPTH);
  localparam int unsigned CW        = $clog2(DEPTH + 1);
  localparam int unsigned ID_LSB    = odt_pkg::REQ_W;
  localparam int unsigned H_LSB     = odt_pkg::REQ_W + ID_WIDTH;
  localparam int unsigned O_ID_LSB  = odt_pkg::STATUS_W;
  localparam int unsigned O_H_LSB   = odt_pkg::STATUS_W + ID_WIDTH;
  localparam int unsigned O_NA_BIT  = odt_pkg::STATUS_W + ID_WIDTH + HANDLE_WIDTH;

  odt_pkg::seq_state_e         state_r, state_nxt;
  logic [odt_pkg::REQ_W-1:0]   req_r;
  logic [ID_WIDTH-1:0]         key_r;
  logic [HANDLE_WIDTH-1:0]     handle_r;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [IW-1:0]               all_idx_r, all_idx_nxt;
  logic [IW-1:0]               all_last_r;
  logic [ID_WIDTH-1:0]         next_id_r, next_id_nxt;
  logic                        out_valid_r;
  logic [OUT_W-1:0]            out_data_r, out_data_nxt;
  logic                        out_last_r;

  logic                        in_fire;
  logic                        out_free;
  odt_pkg::tbl_op_e            tbl_op;
  odt_pkg::slot_flags_t        rd_flags;
  logic [ID_WIDTH-1:0]         rd_id;
  logic [HANDLE_WIDTH-1:0]     rd_handle;
  logic [ID_WIDTH-1:0]         snap_id;
  logic [CW-1:0]               count;
  logic [ID_WIDTH-1:0]         key;
  logic                        fetch_mode;
  logic                        hit;
  logic                        immediate;
  logic                        at_end;
  logic                        resolve;
  logic                        fire;
  logic                        all_is_last;
  logic                        more_aborts;
  logic [odt_pkg::STATUS_W-1:0] res_status;
  logic [ID_WIDTH-1:0]         res_id;
  logic [HANDLE_WIDTH-1:0]     res_handle;
  logic                        res_na;
  logic                        res_last;

  assign in_tready  = (state_r == odt_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Abort-all takes its keys from the snapshot, the other lookups from the request.
  assign key        = (req_r == odt_pkg::REQ_ABORT_ALL) ? snap_id : key_r;
  assign fetch_mode = (req_r == odt_pkg::REQ_FETCH);

  odt_table #(
    .DEPTH        (DEPTH),
    .ID_WIDTH     (ID_WIDTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (tbl_op),
    .pos       (idx_r),
    .wr_id     (next_id_r),
    .wr_handle (handle_r),
    .rd_idx    (idx_r),
    .snap_idx  (all_idx_r),
    .rd_flags  (rd_flags),
    .rd_id     (rd_id),
    .rd_handle (rd_handle),
    .snap_id   (snap_id),
    .count     (count)
  );

  odt_match #(
    .ID_WIDTH (ID_WIDTH)
  ) u_match (
    .fetch_mode (fetch_mode),
    .key        (key),
    .flags      (rd_flags),
    .entry_id   (rd_id),
    .hit        (hit)
  );

  // Scan bookkeeping: when the current request has its answer.
  always_comb begin
    immediate = !((req_r == odt_pkg::REQ_ABORT) || (req_r == odt_pkg::REQ_ABORT_ALL) ||
                  (req_r == odt_pkg::REQ_FETCH) || (req_r == odt_pkg::REQ_RETURN));
    at_end    = (count == '0) || ((CW'(idx_r) + CW'(1)) >= count);
    resolve   = (state_r == odt_pkg::ST_SCAN) && (immediate || hit || at_end);
    fire      = resolve && out_free;
    all_is_last = (all_idx_r == all_last_r);
    more_aborts = (req_r == odt_pkg::REQ_ABORT_ALL) && !all_is_last;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      odt_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = odt_pkg::ST_SCAN;
        end
      end
      odt_pkg::ST_SCAN: begin
        if (fire && !more_aborts) begin
          state_nxt = odt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = odt_pkg::ST_IDLE;
    endcase
  end

  // Result word and table operation for the request being resolved.
  always_comb begin
    res_status = odt_pkg::ST_NOTFOUND;
    res_id     = '0;
    res_handle = '0;
    res_na     = 1'b0;
    res_last   = (req_r != odt_pkg::REQ_ABORT_ALL) || all_is_last;
    tbl_op     = odt_pkg::TBL_NOP;
    case (req_r)
      odt_pkg::REQ_ADD: begin
        if (count >= CW'(DEPTH)) begin
          res_status = odt_pkg::ST_FULL;
        end else begin
          res_status = odt_pkg::ST_ADDED;
          res_id     = next_id_r;
          res_na     = (count == '0);
          tbl_op     = odt_pkg::TBL_APPEND;
        end
      end
      odt_pkg::REQ_ABORT, odt_pkg::REQ_ABORT_ALL: begin
        if (hit) begin
          res_id = key;
          if (rd_flags.busy) begin
            res_status = odt_pkg::ST_PENDING;
            tbl_op     = odt_pkg::TBL_SET_PEND;
          end else begin
            res_status = odt_pkg::ST_REMOVED;
            res_handle = rd_handle;
            tbl_op     = odt_pkg::TBL_REMOVE;
          end
        end
      end
      odt_pkg::REQ_FETCH: begin
        if (hit) begin
          res_status = odt_pkg::ST_FETCHED;
          res_id     = rd_id;
          res_handle = rd_handle;
          tbl_op     = odt_pkg::TBL_SET_BUSY;
        end else begin
          res_status = odt_pkg::ST_NONE;
        end
      end
      odt_pkg::REQ_RETURN: begin
        if (hit) begin
          res_id = key;
          if (rd_flags.busy) begin
            res_status = odt_pkg::ST_UNBLOCKED;
            tbl_op     = odt_pkg::TBL_CLR_BUSY;
          end else begin
            res_status = odt_pkg::ST_DOUBLE;
          end
        end
      end
      default: ;
    endcase

    // Entries change only as the result word loads; abort-all snapshots on acceptance.
    if (!fire) begin
      tbl_op = odt_pkg::TBL_NOP;
    end
    if (in_fire && (in_tdata[odt_pkg::REQ_W-1:0] == odt_pkg::REQ_ABORT_ALL)) begin
      tbl_op = odt_pkg::TBL_SNAP;
    end

    out_data_nxt                                 = '0;
    out_data_nxt[odt_pkg::STATUS_W-1:0]          = res_status;
    out_data_nxt[O_ID_LSB +: ID_WIDTH]           = res_id;
    out_data_nxt[O_H_LSB +: HANDLE_WIDTH]        = res_handle;
    out_data_nxt[O_NA_BIT]                       = res_na;
  end

  // Scan pointers and id counter.
  always_comb begin
    idx_nxt     = idx_r;
    all_idx_nxt = all_idx_r;
    next_id_nxt = next_id_r;
    if (in_fire) begin
      idx_nxt     = '0;
      all_idx_nxt = '0;
    end else if (state_r == odt_pkg::ST_SCAN) begin
      if (fire) begin
        idx_nxt     = '0;
        all_idx_nxt = all_idx_r + IW'(1);
      end else if (!resolve) begin
        idx_nxt = idx_r + IW'(1);
      end
    end
    if (fire && (tbl_op == odt_pkg::TBL_APPEND)) begin
      next_id_nxt = next_id_r + ID_WIDTH'(1);
      if (next_id_nxt == '0) begin
        next_id_nxt = ID_WIDTH'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= odt_pkg::ST_IDLE;
      next_id_r   <= ID_WIDTH'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      next_id_r <= next_id_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request latch, scan pointers and result word.
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    all_idx_r <= all_idx_nxt;
    if (in_fire) begin
      req_r      <= in_tdata[odt_pkg::REQ_W-1:0];
      key_r      <= in_tdata[ID_LSB +: ID_WIDTH];
      handle_r   <= in_tdata[H_LSB +: HANDLE_WIDTH];
      all_last_r <= (count == '0) ? '0 : IW'(count - CW'(1));
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
      out_last_r <= res_last;
    end
  end

endmodule

// ===== sim/tb_ordered_task_dispatch_table_top.sv =====
// Self-checking testbench for ordered_task_dispatch_table_top.
// Depends on odt_pkg and the RTL under sv/; a scoreboard class predicts every result word.
module tb_ordered_task_dispatch_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_DEPTH = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned REQ_BITS  = odt_pkg::REQ_W;
  localparam int unsigned ST_BITS   = odt_pkg::STATUS_W;
  localparam int unsigned IN_BITS   = REQ_BITS + ID_W + HANDLE_W;
  localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = ST_BITS + ID_W + HANDLE_W + 1;
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  // Request codes the block does not define; they must give a single not-found word.
  localparam logic [REQ_BITS-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_BITS-1:0] REQ_SPARE_HI = 3'd7;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 1'b0;

  // Task table predictor and store of expected result words.
  class dispatch_scoreboard;
    typedef struct packed {
      logic [ST_BITS-1:0]  status;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
      logic                fresh;
      logic                last;
    } result_t;

    logic [ID_W-1:0]     slot_id     [TBL_DEPTH];
    logic [HANDLE_W-1:0] slot_handle [TBL_DEPTH];
    bit                  slot_busy   [TBL_DEPTH];
    bit                  slot_pend   [TBL_DEPTH];
    int                  count;
    logic [ID_W-1:0]     next_id;
    result_t             expected_q[$];
    int                  errors;

    function new();
      count   = 0;
      next_id = 1;
      errors  = 0;
    endfunction

    function void push(logic [ST_BITS-1:0] status, logic [ID_W-1:0] id,
                       logic [HANDLE_W-1:0] handle, logic fresh, logic last);
      result_t r;
      r.status = status;
      r.id     = id;
      r.handle = handle;
      r.fresh  = fresh;
      r.last   = last;
      expected_q.push_back(r);
    endfunction

    // Oldest entry carrying the id; id zero never matches.
    function int find(logic [ID_W-1:0] id);
      if (id == '0) return -1;
      for (int i = 0; i < count; i++) begin
        if (slot_id[i] == id) return i;
      end
      return -1;
    endfunction

    // Abort one entry: an idle one leaves the table, a busy one is only marked.
    function void abort_entry(logic [ID_W-1:0] id, logic last);
      int pos;
      logic [HANDLE_W-1:0] h;
      pos = find(id);
      if (pos < 0) begin
        push(odt_pkg::ST_NOTFOUND, '0, '0, 1'b0, last);
      end else if (slot_busy[pos]) begin
        slot_pend[pos] = 1'b1;
        push(odt_pkg::ST_PENDING, id, '0, 1'b0, last);
      end else begin
        h = slot_handle[pos];
        for (int i = pos; i + 1 < count; i++) begin
          slot_id[i]     = slot_id[i+1];
          slot_handle[i] = slot_handle[i+1];
          slot_busy[i]   = slot_busy[i+1];
          slot_pend[i]   = slot_pend[i+1];
        end
        count--;
        slot_busy[count] = 1'b0;
        slot_pend[count] = 1'b0;
        push(odt_pkg::ST_REMOVED, id, h, 1'b0, last);
      end
    endfunction

    // Apply one accepted request word to the table and queue its results.
    function void note_request(logic [REQ_BITS-1:0] req, logic [ID_W-1:0] id,
                               logic [HANDLE_W-1:0] handle);
      logic [ID_W-1:0] snap [TBL_DEPTH];
      int pos;
      int n;
      case (req)
        odt_pkg::REQ_ADD: begin
          if (count >= TBL_DEPTH) begin
            push(odt_pkg::ST_FULL, '0, '0, 1'b0, 1'b1);
          end else begin
            slot_id[count]     = next_id;
            slot_handle[count] = handle;
            slot_busy[count]   = 1'b0;
            slot_pend[count]   = 1'b0;
            push(odt_pkg::ST_ADDED, next_id, '0, count == 0, 1'b1);
            count++;
            next_id++;
            if (next_id == '0) next_id = 1;
          end
        end
        odt_pkg::REQ_ABORT: abort_entry(id, 1'b1);
        odt_pkg::REQ_ABORT_ALL: begin
          n = count;
          if (n == 0) begin
            push(odt_pkg::ST_NOTFOUND, '0, '0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) snap[i] = slot_id[i];
            for (int i = 0; i < n; i++) abort_entry(snap[i], i == n - 1);
          end
        end
        odt_pkg::REQ_FETCH: begin
          pos = -1;
          for (int i = 0; i < count; i++) begin
            if (pos < 0 && !slot_busy[i] && !slot_pend[i]) pos = i;
          end
          if (pos < 0) begin
            push(odt_pkg::ST_NONE, '0, '0, 1'b0, 1'b1);
          end else begin
            slot_busy[pos] = 1'b1;
            push(odt_pkg::ST_FETCHED, slot_id[pos], slot_handle[pos], 1'b0, 1'b1);
          end
        end
        odt_pkg::REQ_RETURN: begin
          pos = find(id);
          if (pos < 0) begin
            push(odt_pkg::ST_NOTFOUND, '0, '0, 1'b0, 1'b1);
          end else if (slot_busy[pos]) begin
            slot_busy[pos] = 1'b0;
            push(odt_pkg::ST_UNBLOCKED, id, '0, 1'b0, 1'b1);
          end else begin
            push(odt_pkg::ST_DOUBLE, id, '0, 1'b0, 1'b1);
          end
        end
        default: push(odt_pkg::ST_NOTFOUND, '0, '0, 1'b0, 1'b1);
      endcase
    endfunction

    // Mostly a live id, sometimes zero or a random value.
    function logic [ID_W-1:0] pick_id();
      if (count > 0 && $urandom_range(9) < 8) return slot_id[$urandom_range(count - 1)];
      if ($urandom_range(1) == 0) return '0;
      return ID_W'($urandom);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_result(logic [OUT_W-1:0] data, logic tlast);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %0h last %0b",
                 $time, data, tlast);
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, data[ST_BITS-1:0]);
      compare_field("out_id", want.id, data[ST_BITS +: ID_W]);
      compare_field("out_handle", want.handle, data[ST_BITS+ID_W +: HANDLE_W]);
      compare_field("newly_available", want.fresh, data[ST_BITS+ID_W+HANDLE_W]);
      compare_field("last", want.last, tlast);
    endfunction
  endclass

  dispatch_scoreboard sb;

  ordered_task_dispatch_table_top #(
    .DEPTH       (TBL_DEPTH),
    .ID_WIDTH    (ID_W),
    .HANDLE_WIDTH(HANDLE_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offer one request word, with random idle cycles first, and wait for its acceptance.
  task automatic send_req(input logic [REQ_BITS-1:0] req, input logic [ID_W-1:0] id,
                          input logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-IN_BITS){1'b0}}, handle, id, req};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, id, handle);
    @(negedge clk);
  endtask

  // Stop offering words until every expected result word has arrived.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Random requests: returns and aborts mostly on live ids, with some noise and unused codes.
  task automatic send_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30)
        send_req(odt_pkg::REQ_ADD, ID_W'($urandom), $urandom);
      else if (r < 55)
        send_req(odt_pkg::REQ_FETCH, ID_W'($urandom), $urandom);
      else if (r < 75)
        send_req(odt_pkg::REQ_RETURN, sb.pick_id(), $urandom);
      else if (r < 90)
        send_req(odt_pkg::REQ_ABORT, sb.pick_id(), $urandom);
      else if (r < 94)
        send_req(odt_pkg::REQ_ABORT_ALL, ID_W'($urandom), $urandom);
      else if (r < 97)
        send_req(REQ_BITS'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO)), ID_W'($urandom),
                 $urandom);
      else
        send_req($urandom_range(1) ? odt_pkg::REQ_RETURN : odt_pkg::REQ_ABORT,
                 ID_W'($urandom), $urandom);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // Stimulus and end of run.
  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 9;
    recv_idle_pct = 81;
    @(negedge clk);

    // Directed: empty table, id zero, fill to full, busy and abort-pending handling.
    send_req(odt_pkg::REQ_FETCH, '0, '0);
    send_req(odt_pkg::REQ_ABORT_ALL, '1, '1);
    send_req(odt_pkg::REQ_ABORT, '0, '0);
    send_req(odt_pkg::REQ_RETURN, '0, '1);
    send_req(odt_pkg::REQ_ADD, '1, '0);
    send_req(odt_pkg::REQ_ADD, '0, '1);
    for (int i = 0; i < TBL_DEPTH - 2; i++)
      send_req(odt_pkg::REQ_ADD, ID_W'($urandom), $urandom);
    send_req(odt_pkg::REQ_ADD, '1, '1);
    send_req(odt_pkg::REQ_FETCH, '0, '0);
    send_req(odt_pkg::REQ_FETCH, '1, '1);
    send_req(odt_pkg::REQ_RETURN, 16'd2, '0);
    send_req(odt_pkg::REQ_RETURN, 16'd2, '0);
    send_req(odt_pkg::REQ_ABORT, 16'd1, '0);
    send_req(odt_pkg::REQ_ABORT, 16'd1, '0);
    send_req(odt_pkg::REQ_RETURN, 16'd1, '0);
    send_req(odt_pkg::REQ_FETCH, '0, '0);
    send_req(odt_pkg::REQ_ABORT, 16'd3, '0);
    send_req(odt_pkg::REQ_RETURN, '1, '0);
    for (int c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++) send_req(REQ_BITS'(c), '1, '1);
    send_req(odt_pkg::REQ_ABORT_ALL, '0, '0);

    // Random, sender mostly busy and receiver mostly stalling; one long hold-off.
    send_random(75);
    @(posedge clk);
    hold_go = 1'b1;
    @(negedge clk);
    send_random(40);
    wait_drain();
    send_random(35);

    // Random, the other way round.
    send_idle_pct = 81;
    recv_idle_pct = 9;
    send_random(150);

    // Random, no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(125);

    wait_drain();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #25ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== ordered_task_dispatch_table_top.f =====
sv/odt_pkg.sv
sv/odt_table.sv
sv/odt_match.sv
sv/ordered_task_dispatch_table_top.sv
sim/tb_ordered_task_dispatch_table_top.sv
